[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge, off while rst is high
`define CHK_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent checked whenever the condition holds
`define CHK_IMPLIES(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

[sv/tfs_pkg.sv]
`timescale 1ns / 1ps

package tfs_pkg;

  // grid limit and field widths
  localparam int MAX_GRID = 1024;
  localparam int CFG_W    = 11;
  localparam int COORD_W  = 10;
  localparam int KIND_W   = 8;
  localparam int HGT_W    = 8;
  localparam int VTX_W    = 21;
  localparam int SHADE_W  = 16;
  localparam int DEPTH_W  = 20;

  // corner heights in quarter units, square root search widths
  localparam int Q_W    = 10;
  localparam int ROOT_W = 20;
  localparam int P_W    = 51;
  localparam int R_W    = 93;

  // register indexes
  localparam logic [0:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_GRID_HEIGHT = 1'b1;

  // shade limits in Q1.15 and the value for a face turned away
  localparam logic [SHADE_W-1:0] SHADE_MIN  = 16'd23593;
  localparam logic [SHADE_W-1:0] SHADE_MAX  = 16'd35389;
  localparam logic [SHADE_W-1:0] SHADE_AWAY = 16'd26214;

  // largest scaled cosine, 0.28 * 2^15 * 100
  localparam logic [ROOT_W-1:0] K_MAX = 20'd917504;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [KIND_W-1:0]  kind;
  } tile_t;

  typedef struct packed {
    logic [VTX_W-1:0]   vtx_nw;
    logic [VTX_W-1:0]   vtx_ne;
    logic [VTX_W-1:0]   vtx_se;
    logic [VTX_W-1:0]   vtx_sw;
    tile_t              tile;
    logic [DEPTH_W-1:0] depth;
  } side_t;

endpackage

[sv/tfs_front.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tfs_front import tfs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [CFG_W-1:0]        grid_w,
  input  logic [CFG_W-1:0]        grid_h,
  input  tile_t                   tile,
  input  logic [8:0][HGT_W-1:0]   hgt,
  output logic                    out_valid,
  output logic [3:0][Q_W-1:0]     q,
  output logic [VTX_W-1:0]        base,
  output logic [CFG_W-1:0]        stride,
  output tile_t                   tile_q
);

  localparam logic [13:0] RECIP6 = 14'd10923;

  logic [CFG_W-1:0]      w_eff;
  logic [CFG_W-1:0]      h_eff;
  logic [CFG_W-1:0]      xe;
  logic [CFG_W-1:0]      ye;
  logic [2:0]            col_ok;
  logic [2:0]            row_ok;
  logic [8:0]            g;
  logic [3:0][Q_W-1:0]   q_next;
  logic [CFG_W-1:0]      stride_next;
  logic [VTX_W-1:0]      base_next;

  // rounded mean of the in-grid tiles around one corner, quarter units
  function automatic logic [Q_W-1:0] corner_q(input logic [3:0][HGT_W-1:0] hv,
                                              input logic [3:0] ok);
    logic [HGT_W+1:0] sum;
    logic [2:0]       cnt;
    logic [12:0]      num;
    logic [26:0]      prod;
    logic [Q_W-1:0]   res;
    sum = '0;
    cnt = '0;
    for (int i = 0; i < 4; i++) begin
      if (ok[i]) begin
        sum = sum + (HGT_W+2)'(hv[i]);
        cnt = cnt + 3'd1;
      end
    end
    num  = {sum, 3'b000} + 13'd3;
    prod = 27'(num) * 27'(RECIP6);
    case (cnt)
      3'd1:    res = Q_W'(sum) << 2;
      3'd2:    res = Q_W'(sum) << 1;
      3'd3:    res = Q_W'(prod >> 16);
      3'd4:    res = Q_W'(sum);
      default: res = '0;
    endcase
    return res;
  endfunction

  // effective grid size
  assign w_eff = (grid_w > CFG_W'(MAX_GRID)) ? CFG_W'(MAX_GRID) : grid_w;
  assign h_eff = (grid_h > CFG_W'(MAX_GRID)) ? CFG_W'(MAX_GRID) : grid_h;
  assign xe    = CFG_W'(tile.x);
  assign ye    = CFG_W'(tile.y);

  // in-grid tests for the three columns and rows
  assign col_ok[0] = (tile.x != '0) && ((xe - CFG_W'(1)) < w_eff);
  assign col_ok[1] = xe < w_eff;
  assign col_ok[2] = (xe + CFG_W'(1)) < w_eff;
  assign row_ok[0] = (tile.y != '0) && ((ye - CFG_W'(1)) < h_eff);
  assign row_ok[1] = ye < h_eff;
  assign row_ok[2] = (ye + CFG_W'(1)) < h_eff;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      g[i] = col_ok[i % 3] && row_ok[i / 3];
    end
  end

  // corners: nw, ne, se, sw
  assign q_next[0] = corner_q({hgt[4], hgt[3], hgt[1], hgt[0]}, {g[4], g[3], g[1], g[0]});
  assign q_next[1] = corner_q({hgt[5], hgt[4], hgt[2], hgt[1]}, {g[5], g[4], g[2], g[1]});
  assign q_next[2] = corner_q({hgt[8], hgt[7], hgt[5], hgt[4]}, {g[8], g[7], g[5], g[4]});
  assign q_next[3] = corner_q({hgt[7], hgt[6], hgt[4], hgt[3]}, {g[7], g[6], g[4], g[3]});

  // row start of the vertex grid
  assign stride_next = w_eff + CFG_W'(1);
  assign base_next   = VTX_W'(tile.y) * VTX_W'(stride_next);

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q      <= q_next;
      base   <= base_next;
      stride <= stride_next;
      tile_q <= tile;
    end
  end

  `CHK_IMPLIES(a_corner_range, out_valid, (q[0] <= Q_W'(1020)) && (q[1] <= Q_W'(1020)) && (q[2] <= Q_W'(1020)) && (q[3] <= Q_W'(1020)), "corner height above four times the largest tile height")

endmodule

[sv/tfs_geom.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tfs_geom import tfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [3:0][Q_W-1:0]   q,
  input  logic [VTX_W-1:0]      base,
  input  logic [CFG_W-1:0]      stride,
  input  tile_t                 tile,
  output logic                  out_valid,
  output side_t                 side,
  output logic                  pos,
  output logic [P_W-1:0]        p,
  output logic [R_W-1:0]        r2
);

  localparam logic [15:0] RECIP50 = 16'd41944;

  // stage 2: corner differences and light vector
  logic [Q_W+1:0]       s_c;
  logic                 v2;
  logic signed [10:0]   a2, b2;
  logic signed [15:0]   lx2, ly2;
  logic signed [12:0]   lz2;
  logic [14:0]          dn2;
  side_t                side2;
  logic [15:0]          lx_mag, ly_mag;
  logic [VTX_W-1:0]     nw_c, sw_c;

  // stage 3: products
  logic                 v3;
  logic signed [26:0]   alx3, bly3;
  logic [19:0]          asq3, bsq3;
  logic [28:0]          lxsq3, lysq3;
  logic [22:0]          lzsq3;
  logic signed [12:0]   lz3;
  logic [30:0]          dprod3;
  side_t                side3;

  // stage 4: dot product and squared lengths
  logic                 v4;
  logic signed [27:0]   d4;
  logic [20:0]          n2_4;
  logic [29:0]          l2_4;
  side_t                side4;
  side_t                side4_next;
  logic [COORD_W:0]     xy_c;

  // stage 5: wide products
  logic                 v5;
  logic                 pos5;
  logic [51:0]          d2_5;
  logic [P_W-1:0]       p5;
  side_t                side5;
  logic [25:0]          du;

  assign s_c    = (Q_W+2)'(q[0]) + (Q_W+2)'(q[1]) + (Q_W+2)'(q[2]) + (Q_W+2)'(q[3]);
  assign lx_mag = 16'd1032 + {2'b00, tile.x, 4'b0000};
  assign ly_mag = 16'd1032 + {2'b00, tile.y, 4'b0000};
  assign nw_c   = base + VTX_W'(tile.x);
  assign sw_c   = nw_c + VTX_W'(stride);

  always_ff @(posedge clk) begin
    if (en) begin
      a2  <= $signed({1'b0, q[1]}) - $signed({1'b0, q[0]});
      b2  <= $signed({1'b0, q[3]}) - $signed({1'b0, q[0]});
      lx2 <= -$signed(lx_mag);
      ly2 <= -$signed(ly_mag);
      lz2 <= 13'sd1536 - $signed({1'b0, s_c});
      dn2 <= {s_c, 3'b000} + 15'd25;
      side2.vtx_nw <= nw_c;
      side2.vtx_ne <= nw_c + VTX_W'(1);
      side2.vtx_sw <= sw_c;
      side2.vtx_se <= sw_c + VTX_W'(1);
      side2.tile   <= tile;
      side2.depth  <= '0;
    end
  end

  // stage 3 products
  always_ff @(posedge clk) begin
    if (en) begin
      alx3   <= 27'(a2) * 27'(lx2);
      bly3   <= 27'(b2) * 27'(ly2);
      asq3   <= 20'(22'(a2) * 22'(a2));
      bsq3   <= 20'(22'(b2) * 22'(b2));
      lxsq3  <= 29'(32'(lx2) * 32'(lx2));
      lysq3  <= 29'(32'(ly2) * 32'(ly2));
      lzsq3  <= 23'(26'(lz2) * 26'(lz2));
      lz3    <= lz2;
      dprod3 <= 31'(dn2) * 31'(RECIP50);
      side3  <= side2;
    end
  end

  // stage 4 sums, depth key from the rounded height term
  assign xy_c = (COORD_W+1)'(side3.tile.x) + (COORD_W+1)'(side3.tile.y);

  always_comb begin
    side4_next       = side3;
    side4_next.depth = DEPTH_W'({xy_c, 8'b0000_0000}) + DEPTH_W'(dprod3 >> 21);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d4    <= 28'sd0 - 28'(alx3) - 28'(bly3) + (28'(lz3) <<< 2);
      n2_4  <= 21'(asq3) + 21'(bsq3) + 21'd16;
      l2_4  <= 30'(lxsq3) + 30'(lysq3) + 30'(lzsq3);
      side4 <= side4_next;
    end
  end

  // stage 5: squared dot product against product of squared lengths
  assign du = d4[25:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pos5  <= !d4[27] && (d4 != '0);
      d2_5  <= (!d4[27]) ? 52'(du) * 52'(du) : '0;
      p5    <= P_W'(n2_4) * P_W'(l2_4);
      side5 <= side4;
    end
  end

  // stage 6: scale to (917504 * d)^2 = 49 * d^2 * 2^34
  always_ff @(posedge clk) begin
    if (en) begin
      r2   <= R_W'({58'(d2_5) * 58'd49, 34'b0});
      p    <= p5;
      pos  <= pos5;
      side <= side5;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v2 <= in_valid;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  `CHK_IMPLIES(a_cos_bound, v5 && pos5, d2_5 <= 52'(p5), "squared dot product exceeds squared lengths")

endmodule

[sv/tfs_root.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tfs_root import tfs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  side_t               side_in,
  input  logic                pos_in,
  input  logic [P_W-1:0]      p,
  input  logic [R_W-1:0]      r2,
  output logic                out_valid,
  output side_t               side,
  output logic                pos,
  output logic [ROOT_W-1:0]   k
);

  // largest k with k*k*p <= r2, one bit per stage, msb first
  logic                vld_s  [ROOT_W+1];
  logic [ROOT_W-1:0]   k_s    [ROOT_W+1];
  side_t               side_s [ROOT_W+1];
  logic                pos_s  [ROOT_W+1];
  logic [R_W-1:0]      rem_s  [ROOT_W];
  logic [R_W-1:0]      kp_s   [ROOT_W];
  logic [P_W-1:0]      p_s    [ROOT_W];

  assign vld_s[0]  = in_valid;
  assign k_s[0]    = '0;
  assign side_s[0] = side_in;
  assign pos_s[0]  = pos_in;
  assign rem_s[0]  = r2;
  assign kp_s[0]   = '0;
  assign p_s[0]    = p;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    localparam int J = ROOT_W - 1 - i;
    logic [R_W-1:0] trial;
    logic           fit;

    // (k + 2^J)^2 p - k^2 p = k p 2^(J+1) + p 2^(2J)
    assign trial = (kp_s[i] << (J + 1)) + (R_W'(p_s[i]) << (2 * J));
    assign fit   = trial <= rem_s[i];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else if (en) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        k_s[i+1]    <= fit ? (k_s[i] | (ROOT_W'(1) << J)) : k_s[i];
        side_s[i+1] <= side_s[i];
        pos_s[i+1]  <= pos_s[i];
      end
    end

    if (i < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[i+1] <= fit ? (rem_s[i] - trial) : rem_s[i];
          kp_s[i+1]  <= fit ? (kp_s[i] + (R_W'(p_s[i]) << J)) : kp_s[i];
          p_s[i+1]   <= p_s[i];
        end
      end
    end
  end

  assign out_valid = vld_s[ROOT_W];
  assign k         = k_s[ROOT_W];
  assign side      = side_s[ROOT_W];
  assign pos       = pos_s[ROOT_W];

  `CHK_IMPLIES(a_root_max, out_valid, k <= K_MAX, "scaled cosine above one")
  `CHK_IMPLIES(a_away_zero, out_valid && !pos, k == '0, "root nonzero for a face turned away")

endmodule

[sv/terrain_face_shade.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Terrain face shader: one tile request in, one face result out, in order.
// A new request is taken every cycle while the pipeline is not held; each
// result passes 1 corner stage, 5 geometry stages, 20 square root stages and
// 2 shade stages. The 20-stage root search, one result bit per stage, sets the
// latency. When m_tready is low while a result is shown, the whole pipeline
// holds and s_tready drops; nothing is lost or repeated. grid_width and
// grid_height should be written only while no request is in flight.

module terrain_face_shade import tfs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // config write port
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  // request stream
  input  logic                s_tvalid,
  output logic                s_tready,
  // tile_x, tile_y, h_nw, h_n, h_ne, h_w, h_center, h_e, h_sw, h_s, h_se
  input  logic [95:0]         s_tdata,
  // tile_kind
  input  logic [KIND_W-1:0]   s_tuser,
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  // vertex_nw, vertex_ne, vertex_se, vertex_sw, face_x, face_y, shade, depth_key
  output logic [143:0]        m_tdata,
  // face_kind
  output logic [KIND_W-1:0]   m_tuser
);

  localparam logic [21:0] SHADE_BIAS = 22'd2621490;
  localparam logic [22:0] RECIP100   = 23'd5368710;

  logic                 en;
  logic [CFG_W-1:0]     grid_w, grid_h;
  tile_t                tile_in;

  logic                 f_valid;
  logic [3:0][Q_W-1:0]  f_q;
  logic [VTX_W-1:0]     f_base;
  logic [CFG_W-1:0]     f_stride;
  tile_t                f_tile;

  logic                 g_valid;
  side_t                g_side;
  logic                 g_pos;
  logic [P_W-1:0]       g_p;
  logic [R_W-1:0]       g_r2;

  logic                 r_valid;
  side_t                r_side;
  logic                 r_pos;
  logic [ROOT_W-1:0]    r_k;

  logic                 a_valid;
  side_t                a_side;
  logic                 a_pos;
  logic [44:0]          a_prod;
  logic [SHADE_W-1:0]   quo;
  logic [SHADE_W-1:0]   shade_next;

  side_t                o_side;
  logic [SHADE_W-1:0]   o_shade;

  // whole pipeline advances unless a shown result is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w <= CFG_W'(MAX_GRID);
      grid_h <= CFG_W'(MAX_GRID);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_w <= cfg_data;
        CFG_GRID_HEIGHT: grid_h <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tile_in.x    = s_tdata[9:0];
  assign tile_in.y    = s_tdata[19:10];
  assign tile_in.kind = s_tuser;

  tfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .grid_w    (grid_w),
    .grid_h    (grid_h),
    .tile      (tile_in),
    .hgt       (s_tdata[91:20]),
    .out_valid (f_valid),
    .q         (f_q),
    .base      (f_base),
    .stride    (f_stride),
    .tile_q    (f_tile)
  );

  tfs_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .q         (f_q),
    .base      (f_base),
    .stride    (f_stride),
    .tile      (f_tile),
    .out_valid (g_valid),
    .side      (g_side),
    .pos       (g_pos),
    .p         (g_p),
    .r2        (g_r2)
  );

  tfs_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .side_in   (g_side),
    .pos_in    (g_pos),
    .p         (g_p),
    .r2        (g_r2),
    .out_valid (r_valid),
    .side      (r_side),
    .pos       (r_pos),
    .k         (r_k)
  );

  // (2621490 + k) / 100 by reciprocal multiply
  always_ff @(posedge clk) begin
    if (en) begin
      a_prod <= 45'(SHADE_BIAS + 22'(r_k)) * 45'(RECIP100);
      a_side <= r_side;
      a_pos  <= r_pos;
    end
  end

  // clamp, or fixed ambient shade for a face turned away
  assign quo = a_prod[44:29];

  always_comb begin
    if (!a_pos) begin
      shade_next = SHADE_AWAY;
    end else if (quo < SHADE_MIN) begin
      shade_next = SHADE_MIN;
    end else if (quo > SHADE_MAX) begin
      shade_next = SHADE_MAX;
    end else begin
      shade_next = quo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      o_side  <= a_side;
      o_shade <= shade_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      a_valid  <= r_valid;
      m_tvalid <= a_valid;
    end
  end

  assign m_tdata = {4'b0000, o_side.depth, o_shade, o_side.tile.y, o_side.tile.x,
                    o_side.vtx_sw, o_side.vtx_se, o_side.vtx_ne, o_side.vtx_nw};
  assign m_tuser = o_side.tile.kind;

  `CHK_IMPLIES(a_shade_range, m_tvalid, (o_shade >= SHADE_MIN) && (o_shade <= SHADE_MAX), "shade outside clamp range")
  `CHK_IMPLIES(a_depth_range, m_tvalid, o_side.depth <= DEPTH_W'(524543), "depth key out of range")

endmodule
